>>> rtl/core/qdce_pkg.sv
// Shared types, codes and helper functions of the QR data codeword encoder.
package qdce_pkg;

    localparam int MESSAGE_BYTES_DEF = 4096;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int CNT_MAX_W = 16;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       last_byte;
    } qdce_in_t;

    typedef struct packed {
        logic [7:0] codeword;
        logic       last_codeword;
        logic [1:0] status;
    } qdce_out_t;

    typedef struct packed {
        logic go;
        logic restart;
    } qdce_emit_ctl_t;

    typedef struct packed {
        logic       done;
        logic [7:0] codeword;
    } qdce_emit_res_t;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_UNPAIRED = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODEWORDS = 2'd1;

    localparam logic [3:0] IND_BYTE   = 4'b0100;
    localparam logic [7:0] IND_HANZI  = 8'hD1;
    localparam logic [7:0] PAD_A      = 8'hEC;
    localparam logic [7:0] PAD_B      = 8'h11;
    localparam logic [7:0] HZ_BASE_LO = 8'hA1;
    localparam logic [7:0] HZ_BASE_HI = 8'hA6;
    localparam logic [7:0] HZ_SPLIT   = 8'hB0;
    localparam logic [7:0] HZ_LO_BASE = 8'hA1;

    typedef enum logic [2:0] {
        P_IDLE,
        P_CALC1,
        P_CALC2,
        P_CALC3,
        P_RUN,
        P_PUSH
    } pull_state_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_BIT,
        E_SEG,
        E_HI,
        E_LO
    } emit_state_t;

    typedef enum logic [2:0] {
        PH_NEWSEG,
        PH_IND,
        PH_CNT,
        PH_FETCH,
        PH_DATA
    } phase_t;

    function automatic int data_width(input int mb, input int ms);
        int w;
        w = $clog2(mb * 8 + ms * 40 + 1);
        return (w > 16) ? w : 16;
    endfunction

    // The multiply by 0x60 is done as two shifts; everything wraps at 13 bits.
    function automatic logic [12:0] hanzi_value(input logic [7:0] hi, input logic [7:0] lo);
        logic [12:0] base;
        logic [12:0] diff;
        logic [12:0] lod;
        base = (hi < HZ_SPLIT) ? 13'(HZ_BASE_LO) : 13'(HZ_BASE_HI);
        diff = 13'(hi) - base;
        lod  = 13'(lo) - 13'(HZ_LO_BASE);
        return (diff << 6) + (diff << 5) + lod;
    endfunction

endpackage

>>> rtl/core/qdce_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module qdce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/qdce_emit.sv
// Bit stream walker that reads the segment table and message store to build codewords.
module qdce_emit #(
    parameter int MESSAGE_BYTES = qdce_pkg::MESSAGE_BYTES_DEF,
    parameter int MAX_SEGMENTS  = qdce_pkg::MAX_SEGMENTS_DEF,
    localparam int AW  = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1,
    localparam int LW  = $clog2(MESSAGE_BYTES + 1),
    localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int SCW = $clog2(MAX_SEGMENTS + 1),
    localparam int DW  = qdce_pkg::data_width(MESSAGE_BYTES, MAX_SEGMENTS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qdce_pkg::qdce_emit_ctl_t ctl,
    input  logic [11:0]              cw_index,
    input  logic [DW-1:0]            data_bits,
    input  logic [DW-1:0]            tail_base,
    input  logic [SCW-1:0]           seg_total,
    input  logic                     bcw16,
    input  logic [4:0]               hcw,
    output logic [SIW-1:0]           seg_raddr,
    input  logic [LW:0]              seg_rdata,
    output logic [AW-1:0]            store_raddr,
    input  logic [7:0]               store_rdata,
    output qdce_pkg::qdce_emit_res_t res
);

    localparam int CNT_W = qdce_pkg::CNT_MAX_W;

    qdce_pkg::emit_state_t state_reg, state_next;
    qdce_pkg::phase_t      phase_reg, phase_next;
    logic [SCW-1:0] seg_cur_reg, seg_cur_next;
    logic [LW-1:0]  seg_base_reg, seg_base_next;
    logic [LW-1:0]  char_addr_reg, char_addr_next;
    logic [LW-1:0]  chars_reg, chars_next;
    logic [LW-1:0]  chars_left_reg, chars_left_next;
    logic [LW-1:0]  len_reg, len_next;
    logic           hz_reg, hz_next;
    logic [3:0]     fld_reg, fld_next;
    logic [12:0]    data_reg, data_next;
    logic [7:0]     hi_reg, hi_next;
    logic [2:0]     bit_idx_reg, bit_idx_next;
    logic [7:0]     acc_reg, acc_next;
    logic           done_reg, done_next;

    logic [DW-1:0]  pos;
    logic [DW-1:0]  tail_off;
    logic [7:0]     pad;
    logic [4:0]     cw_now;
    logic [4:0]     cidx;
    logic [CNT_W-1:0] cnt_ext;
    logic [LW-1:0]  rd_len;
    logic [LW-1:0]  rd_chars;
    logic [LW-1:0]  next_base;
    logic [LW-1:0]  addr_plus1;
    logic           bit_v;
    logic           take;

    assign pos        = DW'({cw_index, bit_idx_reg});
    assign tail_off   = pos - tail_base;
    assign pad        = tail_off[3] ? qdce_pkg::PAD_B : qdce_pkg::PAD_A;
    assign cw_now     = hz_reg ? hcw : (bcw16 ? 5'd16 : 5'd8);
    assign cidx       = cw_now - 5'd1 - {1'b0, fld_reg};
    assign cnt_ext    = CNT_W'(chars_reg);
    assign rd_len     = seg_rdata[LW-1:0];
    assign rd_chars   = seg_rdata[LW] ? (rd_len >> 1) : rd_len;
    assign next_base  = seg_base_reg + len_reg;
    assign addr_plus1 = char_addr_reg + LW'(1);
    assign res.done     = done_reg;
    assign res.codeword = acc_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        seg_cur_next    = seg_cur_reg;
        seg_base_next   = seg_base_reg;
        char_addr_next  = char_addr_reg;
        chars_next      = chars_reg;
        chars_left_next = chars_left_reg;
        len_next        = len_reg;
        hz_next         = hz_reg;
        fld_next        = fld_reg;
        data_next       = data_reg;
        hi_next         = hi_reg;
        bit_idx_next    = bit_idx_reg;
        acc_next        = acc_reg;
        done_next       = 1'b0;
        seg_raddr       = seg_cur_reg[SIW-1:0];
        store_raddr     = char_addr_reg[AW-1:0];
        bit_v           = 1'b0;
        take            = 1'b0;

        case (state_reg)
            qdce_pkg::E_IDLE:
            begin
                if (ctl.restart)
                begin
                    seg_cur_next  = '0;
                    seg_base_next = '0;
                    phase_next    = qdce_pkg::PH_NEWSEG;
                end
                if (ctl.go)
                begin
                    bit_idx_next = 3'd0;
                    state_next   = qdce_pkg::E_BIT;
                end
            end
            qdce_pkg::E_BIT:
            begin
                if (pos >= data_bits)
                begin
                    bit_v = (pos < tail_base) ? 1'b0 : pad[~tail_off[2:0]];
                    take  = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        qdce_pkg::PH_NEWSEG:
                        begin
                            if (seg_cur_reg >= seg_total)
                            begin
                                take = 1'b1;
                            end
                            else
                            begin
                                state_next = qdce_pkg::E_SEG;
                            end
                        end
                        qdce_pkg::PH_IND:
                        begin
                            bit_v = hz_reg ? qdce_pkg::IND_HANZI[3'(3'd7 - fld_reg[2:0])]
                                           : qdce_pkg::IND_BYTE[2'(2'd3 - fld_reg[1:0])];
                            take  = 1'b1;
                            if (fld_reg == (hz_reg ? 4'd7 : 4'd3))
                            begin
                                fld_next   = 4'd0;
                                phase_next = qdce_pkg::PH_CNT;
                            end
                            else
                            begin
                                fld_next = fld_reg + 4'd1;
                            end
                        end
                        qdce_pkg::PH_CNT:
                        begin
                            bit_v = cnt_ext[cidx[3:0]];
                            take  = 1'b1;
                            if ({1'b0, fld_reg} == cw_now - 5'd1)
                            begin
                                fld_next   = 4'd0;
                                phase_next = qdce_pkg::PH_FETCH;
                            end
                            else
                            begin
                                fld_next = fld_reg + 4'd1;
                            end
                        end
                        qdce_pkg::PH_FETCH:
                        begin
                            state_next = qdce_pkg::E_HI;
                        end
                        qdce_pkg::PH_DATA:
                        begin
                            bit_v     = data_reg[12];
                            take      = 1'b1;
                            data_next = {data_reg[11:0], 1'b0};
                            if (fld_reg == (hz_reg ? 4'd12 : 4'd7))
                            begin
                                fld_next        = 4'd0;
                                chars_left_next = chars_left_reg - LW'(1);
                                if (chars_left_reg == LW'(1))
                                begin
                                    seg_cur_next   = seg_cur_reg + SCW'(1);
                                    seg_base_next  = next_base;
                                    char_addr_next = next_base;
                                    phase_next     = qdce_pkg::PH_NEWSEG;
                                end
                                else
                                begin
                                    char_addr_next = char_addr_reg + (hz_reg ? LW'(2) : LW'(1));
                                    phase_next     = qdce_pkg::PH_FETCH;
                                end
                            end
                            else
                            begin
                                fld_next = fld_reg + 4'd1;
                            end
                        end
                        default:
                        begin
                            phase_next = qdce_pkg::PH_NEWSEG;
                        end
                    endcase
                end
                if (take)
                begin
                    acc_next = {acc_reg[6:0], bit_v};
                    if (bit_idx_reg == 3'd7)
                    begin
                        done_next  = 1'b1;
                        state_next = qdce_pkg::E_IDLE;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                    end
                end
            end
            qdce_pkg::E_SEG:
            begin
                state_next = qdce_pkg::E_BIT;
                if (rd_chars == '0)
                begin
                    seg_cur_next  = seg_cur_reg + SCW'(1);
                    seg_base_next = seg_base_reg + rd_len;
                end
                else
                begin
                    hz_next         = seg_rdata[LW];
                    len_next        = rd_len;
                    chars_next      = rd_chars;
                    chars_left_next = rd_chars;
                    char_addr_next  = seg_base_reg;
                    fld_next        = 4'd0;
                    phase_next      = qdce_pkg::PH_IND;
                end
            end
            qdce_pkg::E_HI:
            begin
                if (hz_reg)
                begin
                    hi_next     = store_rdata;
                    store_raddr = addr_plus1[AW-1:0];
                    state_next  = qdce_pkg::E_LO;
                end
                else
                begin
                    data_next  = {store_rdata, 5'b0};
                    phase_next = qdce_pkg::PH_DATA;
                    state_next = qdce_pkg::E_BIT;
                end
            end
            qdce_pkg::E_LO:
            begin
                data_next  = qdce_pkg::hanzi_value(hi_reg, store_rdata);
                phase_next = qdce_pkg::PH_DATA;
                state_next = qdce_pkg::E_BIT;
            end
            default:
            begin
                state_next = qdce_pkg::E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= qdce_pkg::E_IDLE;
            phase_reg    <= qdce_pkg::PH_NEWSEG;
            seg_cur_reg  <= '0;
            seg_base_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            seg_cur_reg  <= seg_cur_next;
            seg_base_reg <= seg_base_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_addr_reg  <= char_addr_next;
        chars_reg      <= chars_next;
        chars_left_reg <= chars_left_next;
        len_reg        <= len_next;
        hz_reg         <= hz_next;
        fld_reg        <= fld_next;
        data_reg       <= data_next;
        hi_reg         <= hi_next;
        bit_idx_reg    <= bit_idx_next;
        acc_reg        <= acc_next;
    end

endmodule

>>> rtl/core/qr_data_codeword_encoder.sv
// Top level of the QR data codeword encoder for byte and GB2312 Hanzi segments.
//
//  Channel | Signals                            | Direction | Meaning
//  in      | in_valid, in_ready, in_data        | sink      | load a byte or pull a codeword
//  out     | out_valid, out_ready, out_data     | source    | at most one codeword item per pull
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | sink      | version and data codeword count
//          | cfg_data                           |           |
//
// A load that does not overflow writes the message store and the segment table once each.
// A pull passes the bit count pipeline, then shifts in the stream bits one at a time, with a
// segment table read per segment and a message store read per character (two per Hanzi), sees
// the end and hands the item to the output register; no load or pull is accepted until then.
// Reset clears all control state; the memories are not cleared, only written entries are read.
// A finished codeword waits in the output register; the next item is accepted meanwhile.
module qr_data_codeword_encoder #(
    parameter int MESSAGE_BYTES = qdce_pkg::MESSAGE_BYTES_DEF,
    parameter int MAX_SEGMENTS  = qdce_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  qdce_pkg::qdce_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output qdce_pkg::qdce_out_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qdce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [11:0]                      cfg_data
);

    localparam int AW  = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
    localparam int LW  = $clog2(MESSAGE_BYTES + 1);
    localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW  = qdce_pkg::data_width(MESSAGE_BYTES, MAX_SEGMENTS);

    qdce_pkg::pull_state_t pstate_reg, pstate_next;
    logic [5:0]     version_reg, version_next;
    logic [11:0]    dcw_reg, dcw_next;
    logic [SCW-1:0] seg_total_reg, seg_total_next;
    logic [LW-1:0]  loaded_reg, loaded_next;
    logic           closed_reg, closed_next;
    logic           ovf_reg, ovf_next;
    logic           last_hz_reg, last_hz_next;
    logic [LW-1:0]  last_len_reg, last_len_next;
    logic [SCW-1:0] nb_reg, nb_next;
    logic [SCW-1:0] nh_reg, nh_next;
    logic [LW-1:0]  bchars_reg, bchars_next;
    logic [LW-1:0]  hchars_reg, hchars_next;
    logic [LW-1:0]  maxb_reg, maxb_next;
    logic [LW-1:0]  maxh_reg, maxh_next;
    logic [11:0]    cw_idx_reg, cw_idx_next;
    logic           out_valid_reg, out_valid_next;
    qdce_pkg::qdce_out_t out_reg, out_next;

    logic [DW-1:0]  tb_reg, th_reg, tbc_reg, thc_reg;
    logic [DW-1:0]  d_reg;
    logic [DW-1:0]  tail_b_reg;
    logic [1:0]     status_reg;

    logic           bcw16;
    logic [4:0]     hcw;
    logic [DW-1:0]  cap;
    logic [DW-1:0]  gap;
    logic [DW-1:0]  term_t;
    logic [DW-1:0]  tail_sum;
    logic           cnt_big;
    logic           pend_now;
    logic [1:0]     status_now;

    logic           load_acc;
    logic           pull_acc;
    logic           cfg_acc;
    logic           restart;
    logic [SCW-1:0] tot_e;
    logic           pend_e;
    logic           hz_in;
    logic           append;
    logic           new_seg;
    logic           seg_hz_a;
    logic [LW-1:0]  len_old;
    logic [LW-1:0]  len_new;
    logic [SCW-1:0] tot_after;

    logic           store_we;
    logic           seg_we;
    logic [SIW-1:0] seg_raddr;
    logic [LW:0]    seg_rdata;
    logic [AW-1:0]  store_raddr;
    logic [7:0]     store_rdata;
    qdce_pkg::qdce_emit_ctl_t emit_ctl;
    qdce_pkg::qdce_emit_res_t emit_res;

    assign in_ready  = (pstate_reg == qdce_pkg::P_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign load_acc  = in_valid && in_ready && (in_data.func == qdce_pkg::FUNC_LOAD);
    assign pull_acc  = in_valid && in_ready && (in_data.func == qdce_pkg::FUNC_PULL);
    assign cfg_acc   = cfg_valid && cfg_ready
                       && ((cfg_index == qdce_pkg::CFG_VERSION)
                           || (cfg_index == qdce_pkg::CFG_CODEWORDS));
    assign restart   = load_acc || cfg_acc;

    assign bcw16    = (version_reg > 6'd9);
    assign hcw      = (version_reg <= 6'd9) ? 5'd8 : ((version_reg <= 6'd26) ? 5'd10 : 5'd12);
    assign cap      = DW'({dcw_reg, 3'b000});
    assign gap      = cap - d_reg;
    assign term_t   = (cap > d_reg) ? ((gap < DW'(4)) ? gap : DW'(4)) : '0;
    assign tail_sum = d_reg + term_t + DW'(7);
    assign cnt_big  = (bcw16 ? 1'b0 : (maxb_reg > LW'(255)))
                      || ((hcw == 5'd8) ? (maxh_reg > LW'(255))
                          : ((hcw == 5'd10) ? (32'(maxh_reg) > 32'd1023)
                                            : (32'(maxh_reg) > 32'd4095)));
    assign pend_now = (seg_total_reg != '0) && last_hz_reg && last_len_reg[0];
    assign status_now = (ovf_reg || (d_reg > cap) || cnt_big) ? qdce_pkg::ST_OVERFLOW
                        : (pend_now ? qdce_pkg::ST_UNPAIRED : qdce_pkg::ST_OK);

    // Load and config path: config writes, segment bookkeeping and running totals for the bit count.
    always_comb
    begin
        version_next   = version_reg;
        dcw_next       = dcw_reg;
        seg_total_next = seg_total_reg;
        loaded_next    = loaded_reg;
        closed_next    = closed_reg;
        ovf_next       = ovf_reg;
        last_hz_next   = last_hz_reg;
        last_len_next  = last_len_reg;
        nb_next        = nb_reg;
        nh_next        = nh_reg;
        bchars_next    = bchars_reg;
        hchars_next    = hchars_reg;
        maxb_next      = maxb_reg;
        maxh_next      = maxh_reg;
        append         = 1'b0;
        new_seg        = 1'b0;
        hz_in          = in_data.data_byte[7];
        store_we       = 1'b0;
        seg_we         = 1'b0;

        if (cfg_acc)
        begin
            if (cfg_index == qdce_pkg::CFG_VERSION)
            begin
                version_next = cfg_data[5:0];
            end
            else
            begin
                dcw_next = cfg_data;
            end
        end

        if (load_acc && closed_reg)
        begin
            seg_total_next = '0;
            loaded_next    = '0;
            ovf_next       = 1'b0;
            nb_next        = '0;
            nh_next        = '0;
            bchars_next    = '0;
            hchars_next    = '0;
            maxb_next      = '0;
            maxh_next      = '0;
        end

        tot_e  = seg_total_next;
        pend_e = (tot_e != '0) && last_hz_reg && last_len_reg[0];

        if (load_acc)
        begin
            closed_next = in_data.last_byte;
            if (32'(loaded_next) >= MESSAGE_BYTES)
            begin
                ovf_next = 1'b1;
            end
            else if (pend_e)
            begin
                append = 1'b1;
            end
            else if ((tot_e != '0) && (last_hz_reg == hz_in))
            begin
                append = 1'b1;
            end
            else if (32'(tot_e) < MAX_SEGMENTS)
            begin
                append  = 1'b1;
                new_seg = 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        seg_hz_a  = new_seg ? hz_in : last_hz_reg;
        len_old   = new_seg ? '0 : last_len_reg;
        len_new   = len_old + LW'(1);
        tot_after = new_seg ? (tot_e + SCW'(1)) : tot_e;

        if (append)
        begin
            store_we       = 1'b1;
            seg_we         = 1'b1;
            seg_total_next = tot_after;
            loaded_next    = loaded_next + LW'(1);
            last_hz_next   = seg_hz_a;
            last_len_next  = len_new;
            if (!seg_hz_a)
            begin
                bchars_next = bchars_next + LW'(1);
                if (len_old == '0)
                begin
                    nb_next = nb_next + SCW'(1);
                end
                if (len_new > maxb_next)
                begin
                    maxb_next = len_new;
                end
            end
            else if (!len_new[0])
            begin
                hchars_next = hchars_next + LW'(1);
                if (len_new == LW'(2))
                begin
                    nh_next = nh_next + SCW'(1);
                end
                if ((len_new >> 1) > maxh_next)
                begin
                    maxh_next = len_new >> 1;
                end
            end
        end
    end

    // Pull sequencing and the output register.
    always_comb
    begin
        pstate_next    = pstate_reg;
        cw_idx_next    = cw_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        emit_ctl.go      = 1'b0;
        emit_ctl.restart = restart;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (restart)
        begin
            cw_idx_next = '0;
        end

        case (pstate_reg)
            qdce_pkg::P_IDLE:
            begin
                if (pull_acc && (cw_idx_reg < dcw_reg))
                begin
                    pstate_next = qdce_pkg::P_CALC1;
                end
            end
            qdce_pkg::P_CALC1:
            begin
                pstate_next = qdce_pkg::P_CALC2;
            end
            qdce_pkg::P_CALC2:
            begin
                pstate_next = qdce_pkg::P_CALC3;
            end
            qdce_pkg::P_CALC3:
            begin
                emit_ctl.go = 1'b1;
                pstate_next = qdce_pkg::P_RUN;
            end
            qdce_pkg::P_RUN:
            begin
                if (emit_res.done)
                begin
                    pstate_next = qdce_pkg::P_PUSH;
                end
            end
            qdce_pkg::P_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.codeword      = emit_res.codeword;
                    out_next.last_codeword = ((cw_idx_reg + 12'd1) == dcw_reg);
                    out_next.status        = status_reg;
                    out_valid_next         = 1'b1;
                    cw_idx_next            = cw_idx_reg + 12'd1;
                    pstate_next            = qdce_pkg::P_IDLE;
                end
            end
            default:
            begin
                pstate_next = qdce_pkg::P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstate_reg    <= qdce_pkg::P_IDLE;
            version_reg   <= 6'd1;
            dcw_reg       <= 12'd19;
            seg_total_reg <= '0;
            loaded_reg    <= '0;
            closed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            last_hz_reg   <= 1'b0;
            last_len_reg  <= '0;
            nb_reg        <= '0;
            nh_reg        <= '0;
            bchars_reg    <= '0;
            hchars_reg    <= '0;
            maxb_reg      <= '0;
            maxh_reg      <= '0;
            cw_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pstate_reg    <= pstate_next;
            version_reg   <= version_next;
            dcw_reg       <= dcw_next;
            seg_total_reg <= seg_total_next;
            loaded_reg    <= loaded_next;
            closed_reg    <= closed_next;
            ovf_reg       <= ovf_next;
            last_hz_reg   <= last_hz_next;
            last_len_reg  <= last_len_next;
            nb_reg        <= nb_next;
            nh_reg        <= nh_next;
            bchars_reg    <= bchars_next;
            hchars_reg    <= hchars_next;
            maxb_reg      <= maxb_next;
            maxh_reg      <= maxh_next;
            cw_idx_reg    <= cw_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Bit count pipeline: products, then the sum, then tail boundary and status.
    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        tb_reg     <= DW'(nb_reg) * DW'(bcw16 ? 5'd20 : 5'd12);
        th_reg     <= DW'(nh_reg) * DW'(5'd8 + hcw);
        tbc_reg    <= DW'(bchars_reg) << 3;
        thc_reg    <= DW'(hchars_reg) * DW'(13);
        d_reg      <= tb_reg + th_reg + tbc_reg + thc_reg;
        tail_b_reg <= {tail_sum[DW-1:3], 3'b000};
        status_reg <= status_now;
    end

    qdce_ram #(
        .WIDTH (8),
        .DEPTH (MESSAGE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (loaded_next[AW-1:0] - AW'(1)),
        .wdata (in_data.data_byte),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    qdce_ram #(
        .WIDTH (LW + 1),
        .DEPTH (MAX_SEGMENTS)
    ) u_segs (
        .clk   (clk),
        .we    (seg_we),
        .waddr (SIW'(tot_after - SCW'(1))),
        .wdata ({seg_hz_a, len_new}),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    qdce_emit #(
        .MESSAGE_BYTES (MESSAGE_BYTES),
        .MAX_SEGMENTS  (MAX_SEGMENTS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (emit_ctl),
        .cw_index    (cw_idx_reg),
        .data_bits   (d_reg),
        .tail_base   (tail_b_reg),
        .seg_total   (seg_total_reg),
        .bcw16       (bcw16),
        .hcw         (hcw),
        .seg_raddr   (seg_raddr),
        .seg_rdata   (seg_rdata),
        .store_raddr (store_raddr),
        .store_rdata (store_rdata),
        .res         (emit_res)
    );

endmodule

>>> rtl/core/qdce_checker.sv
// Port-level checker for the QR data codeword encoder, bound to the top level.
module qdce_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input qdce_pkg::qdce_in_t             in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input qdce_pkg::qdce_out_t            out_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [qdce_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [11:0]                    cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output item changed while stalled.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == qdce_pkg::ST_OK)
                      || (out_data.status == qdce_pkg::ST_OVERFLOW)
                      || (out_data.status == qdce_pkg::ST_UNPAIRED))
        else $error("Undefined status code.");

    a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.func == qdce_pkg::FUNC_LOAD) && !out_valid
        |=> !out_valid)
        else $error("A load produced an output item.");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_codeword |=> !out_valid)
        else $error("Item followed the final codeword at once.");

endmodule

bind qr_data_codeword_encoder qdce_checker u_qdce_checker (.*);
